@@ hdl/lmsd_pkg.sv @@
// ----------------------------------------------------------------------------
// lmsd_pkg
// Shared types and constants of the LED matrix row scan driver.
// ----------------------------------------------------------------------------
package lmsd_pkg;

    localparam int CHAR_SLOTS  = 256;
    localparam int SCAN_ROWS   = 16;
    localparam int ROW_W       = 4;
    localparam int SLOT_W      = $clog2(CHAR_SLOTS);
    localparam int SLOT_CALC_W = 11;
    localparam int STORE_DEPTH = CHAR_SLOTS * SCAN_ROWS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int QUARTER_W   = 7;
    localparam int ON_TICKS_W  = 16;

    localparam logic [QUARTER_W-1:0] QUARTER_MAX = 7'd64;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DATA_POLARITY     = 3'd0,
        CFG_OE_ACTIVE_LEVEL   = 3'd1,
        CFG_BYTES_PER_QUARTER = 3'd2,
        CFG_ON_TICKS          = 3'd3,
        CFG_SCAN_STOP         = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_SHIFT = 3'b001,
        PH_LATCH = 3'b010,
        PH_LIT   = 3'b100
    } t_phase;

    typedef struct packed {
        logic                  data_polarity;
        logic                  oe_active_level;
        logic [QUARTER_W-1:0]  bytes_per_quarter;
        logic [ON_TICKS_W-1:0] on_ticks;
        logic                  scan_stop;
    } t_cfg;

    typedef struct packed {
        logic             shift;
        logic             latch;
        logic             oe;
        logic [ROW_W-1:0] row_lines;
        logic             done;
        logic [2:0]       bit_idx;
        logic             upper_ok;
        logic             lower_ok;
    } t_tick_info;

endpackage

@@ hdl/lmsd_store.sv @@
// ----------------------------------------------------------------------------
// lmsd_store
// Display byte store: one write port, two registered read ports, and a
// clearing pass through every entry after reset.
// ----------------------------------------------------------------------------
module lmsd_store (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_wr_en,
    input  logic [lmsd_pkg::ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]                i_wr_data,
    input  logic                      i_rd_en,
    input  logic [lmsd_pkg::ADDR_W-1:0] i_rd_addr_a,
    input  logic [lmsd_pkg::ADDR_W-1:0] i_rd_addr_b,
    output logic [7:0]                o_rd_data_a,
    output logic [7:0]                o_rd_data_b,
    output logic                      o_busy
);
    import lmsd_pkg::*;

    logic [7:0]        r_mem [STORE_DEPTH];
    logic [7:0]        r_rd_a;
    logic [7:0]        r_rd_b;
    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              w_en;
    logic [ADDR_W-1:0] w_addr;
    logic [7:0]        w_data;

    assign w_en   = r_clearing | i_wr_en;
    assign w_addr = r_clearing ? r_clr_addr : i_wr_addr;
    assign w_data = r_clearing ? 8'd0 : i_wr_data;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;
    assign o_busy      = r_clearing;

endmodule

@@ hdl/lmsd_scan.sv @@
// ----------------------------------------------------------------------------
// lmsd_scan
// Scan sequencer: walks shift, latch and lit phases row by row and issues
// the two store addresses and the pin record for each tick.
// ----------------------------------------------------------------------------
module lmsd_scan (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_tick,
    input  lmsd_pkg::t_cfg              i_cfg,
    output logic [lmsd_pkg::ADDR_W-1:0] o_rd_addr_a,
    output logic [lmsd_pkg::ADDR_W-1:0] o_rd_addr_b,
    output lmsd_pkg::t_tick_info        o_info
);
    import lmsd_pkg::*;

    logic [ROW_W-1:0]      r_scan_row;
    logic [6:0]            r_pair;
    logic [2:0]            r_bit;
    t_phase                r_phase;
    logic [ON_TICKS_W-1:0] r_lit;
    logic [ROW_W-1:0]      r_row_lines;

    logic [ROW_W-1:0]      n_scan_row;
    logic [6:0]            n_pair;
    logic [2:0]            n_bit;
    t_phase                n_phase;
    logic [ON_TICKS_W-1:0] n_lit;
    logic [ROW_W-1:0]      n_row_lines;

    logic [QUARTER_W-1:0]   q;
    logic [7:0]             two_q;
    logic [7:0]             pair_ext;
    logic [7:0]             pair_inc;
    logic                   past_end;
    t_phase                 eff_phase;
    logic [ON_TICKS_W:0]    lit_inc;
    logic [SLOT_CALC_W-1:0] slot_a;
    logic [SLOT_CALC_W-1:0] slot_b;
    logic [SLOT_CALC_W-1:0] pair_w;
    logic [SLOT_CALC_W-1:0] q_w;
    t_tick_info             info;

    assign q        = (i_cfg.bytes_per_quarter > QUARTER_MAX) ? QUARTER_MAX
                                                              : i_cfg.bytes_per_quarter;
    assign two_q    = {q, 1'b0};
    assign pair_ext = {1'b0, r_pair};
    assign pair_inc = pair_ext + 8'd1;
    assign past_end = (r_phase == PH_SHIFT) && (pair_ext >= two_q);
    assign eff_phase = past_end ? PH_LATCH : r_phase;
    assign lit_inc  = {1'b0, r_lit} + 17'd1;

    assign pair_w = SLOT_CALC_W'(r_pair);
    assign q_w    = SLOT_CALC_W'(q);
    assign slot_a = (pair_ext < {1'b0, q}) ? pair_w : pair_w + q_w;
    assign slot_b = (pair_ext < {1'b0, q}) ? pair_w + q_w : pair_w + q_w + q_w;

    assign o_rd_addr_a = {slot_a[SLOT_W-1:0], r_scan_row};
    assign o_rd_addr_b = {slot_b[SLOT_W-1:0], r_scan_row};

    always_comb begin
        n_scan_row  = r_scan_row;
        n_pair      = r_pair;
        n_bit       = r_bit;
        n_phase     = r_phase;
        n_lit       = r_lit;
        n_row_lines = r_row_lines;

        info           = '0;
        info.oe        = ~i_cfg.oe_active_level;
        info.bit_idx   = r_bit;
        info.upper_ok  = slot_a < SLOT_CALC_W'(CHAR_SLOTS);
        info.lower_ok  = slot_b < SLOT_CALC_W'(CHAR_SLOTS);

        if (i_cfg.scan_stop) begin
            n_scan_row = '0;
            n_pair     = '0;
            n_bit      = '0;
            n_phase    = PH_SHIFT;
            n_lit      = '0;
        end else begin
            case (eff_phase)
                PH_SHIFT: begin
                    info.shift = 1'b1;
                    if (r_bit == 3'd7) begin
                        n_bit  = '0;
                        n_pair = pair_inc[6:0];
                        if (pair_inc >= two_q) begin
                            n_pair  = '0;
                            n_phase = PH_LATCH;
                        end
                    end else begin
                        n_bit = r_bit + 3'd1;
                    end
                end
                PH_LATCH: begin
                    info.latch  = 1'b1;
                    n_row_lines = r_scan_row;
                    n_pair      = '0;
                    n_bit       = '0;
                    n_lit       = '0;
                    n_phase     = PH_LIT;
                end
                PH_LIT: begin
                    info.oe = i_cfg.oe_active_level;
                    if (lit_inc >= {1'b0, i_cfg.on_ticks}) begin
                        info.done  = (r_scan_row == ROW_W'(SCAN_ROWS - 1));
                        n_scan_row = r_scan_row + 1'b1;
                        n_lit      = '0;
                        n_pair     = '0;
                        n_bit      = '0;
                        n_phase    = PH_SHIFT;
                    end else begin
                        n_lit = lit_inc[ON_TICKS_W-1:0];
                    end
                end
                default: begin
                    n_phase = PH_SHIFT;
                end
            endcase
        end
        info.row_lines = n_row_lines;
    end

    assign o_info = info;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_row  <= '0;
            r_pair      <= '0;
            r_bit       <= '0;
            r_phase     <= PH_SHIFT;
            r_lit       <= '0;
            r_row_lines <= '0;
        end else if (i_tick) begin
            r_scan_row  <= n_scan_row;
            r_pair      <= n_pair;
            r_bit       <= n_bit;
            r_phase     <= n_phase;
            r_lit       <= n_lit;
            r_row_lines <= n_row_lines;
        end
    end

endmodule

@@ hdl/led_matrix_row_scan_driver_core.sv @@
// ----------------------------------------------------------------------------
// led_matrix_row_scan_driver_core
// Path: an accepted tick beat is registered in the stage-one registers, then in the output registers.
// Throughput: one beat per cycle while the input is not stalled; write beats give no result.
// Reset: the display store is cleared one entry a cycle through all STORE_DEPTH
// entries (4096 at 256 slots); input stays stalled until the pass ends.
// Configuration resets to polarity 1, OE level 0, quarter 16, 70 ticks, run.
// ----------------------------------------------------------------------------
module led_matrix_row_scan_driver_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [lmsd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lmsd_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_mode,
    input  logic [7:0]                        i_write_slot,
    input  logic [3:0]                        i_write_row,
    input  logic [7:0]                        i_write_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_red_upper,
    output logic                              o_red_lower,
    output logic                              o_shift_pulse,
    output logic                              o_latch_strobe,
    output logic                              o_oe_level,
    output logic [3:0]                        o_row_select,
    output logic                              o_frame_done
);
    import lmsd_pkg::*;

    t_cfg                   r_cfg;
    logic                   r_s1_valid;
    t_tick_info             r_s1_info;
    logic                   r_out_valid;
    logic                   r_red_upper;
    logic                   r_red_lower;
    logic                   r_shift_pulse;
    logic                   r_latch_strobe;
    logic                   r_oe_level;
    logic [ROW_W-1:0]       r_row_select;
    logic                   r_frame_done;

    logic                   busy;
    logic                   out_free;
    logic                   in_acc;
    logic                   tick;
    logic                   wr_en;
    logic [SLOT_CALC_W-1:0] wr_slot;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ADDR_W-1:0]      rd_addr_a;
    logic [ADDR_W-1:0]      rd_addr_b;
    logic [7:0]             rd_data_a;
    logic [7:0]             rd_data_b;
    logic [7:0]             byte_a;
    logic [7:0]             byte_b;
    t_tick_info             info;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = busy || (r_s1_valid && !out_free);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign tick       = in_acc && !i_mode;
    assign wr_slot    = SLOT_CALC_W'(i_write_slot);
    assign wr_en      = in_acc && i_mode && (wr_slot < SLOT_CALC_W'(CHAR_SLOTS));
    assign wr_addr    = {wr_slot[SLOT_W-1:0], i_write_row};

    lmsd_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (tick),
        .i_cfg       (r_cfg),
        .o_rd_addr_a (rd_addr_a),
        .o_rd_addr_b (rd_addr_b),
        .o_info      (info)
    );

    lmsd_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (i_write_byte),
        .i_rd_en     (tick),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_data_a),
        .o_rd_data_b (rd_data_b),
        .o_busy      (busy)
    );

    // invert on polarity 0; out-of-range slots read as zero
    assign byte_a = r_s1_info.upper_ok ? (rd_data_a ^ {8{~r_cfg.data_polarity}}) : 8'd0;
    assign byte_b = r_s1_info.lower_ok ? (rd_data_b ^ {8{~r_cfg.data_polarity}}) : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.data_polarity     <= 1'b1;
            r_cfg.oe_active_level   <= 1'b0;
            r_cfg.bytes_per_quarter <= 7'd16;
            r_cfg.on_ticks          <= 16'd70;
            r_cfg.scan_stop         <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_DATA_POLARITY:     r_cfg.data_polarity     <= i_cfg_data[0];
                CFG_OE_ACTIVE_LEVEL:   r_cfg.oe_active_level   <= i_cfg_data[0];
                CFG_BYTES_PER_QUARTER: r_cfg.bytes_per_quarter <= i_cfg_data[QUARTER_W-1:0];
                CFG_ON_TICKS:          r_cfg.on_ticks          <= i_cfg_data[ON_TICKS_W-1:0];
                CFG_SCAN_STOP:         r_cfg.scan_stop         <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (tick) begin
                r_s1_valid <= 1'b1;
            end else if (out_free) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick) begin
            r_s1_info <= info;
        end
        if (out_free && r_s1_valid) begin
            r_red_upper    <= r_s1_info.shift & byte_a[r_s1_info.bit_idx];
            r_red_lower    <= r_s1_info.shift & byte_b[r_s1_info.bit_idx];
            r_shift_pulse  <= r_s1_info.shift;
            r_latch_strobe <= r_s1_info.latch;
            r_oe_level     <= r_s1_info.oe;
            r_row_select   <= r_s1_info.row_lines;
            r_frame_done   <= r_s1_info.done;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_red_upper    = r_red_upper;
    assign o_red_lower    = r_red_lower;
    assign o_shift_pulse  = r_shift_pulse;
    assign o_latch_strobe = r_latch_strobe;
    assign o_oe_level     = r_oe_level;
    assign o_row_select   = r_row_select;
    assign o_frame_done   = r_frame_done;

    a_shift_latch_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_shift_pulse && o_latch_strobe))
        else $error("shift and latch in the same beat");

    a_done_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_done) |-> (o_row_select == ROW_W'(SCAN_ROWS - 1)))
        else $error("frame done away from the last row");

    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (o_in_stall && !r_s1_valid))
        else $error("beat taken during store clearing");

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LED matrix row scan driver core. Write beats
// load the panel store and tick beats return one set of pin levels each.
// A cycle-level model of the scan predicts every pin beat, which is then
// compared field by field with the block's output, in order. Both sides
// idle and stall at random. The register settings change between phases,
// including a quarter of zero and above range, zero and full-scale lit
// counts, inverted data and a halted scan.
// ----------------------------------------------------------------------------
module tb;
    import lmsd_pkg::*;

    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_WRITE  = 1'b1;
    localparam int   MAX_IDLE    = 12;
    localparam int   HOLD_CYCLES = 60;
    localparam int   RANDOM_BEATS = 500;
    localparam int   CYCLE_LIMIT = 200000;
    localparam int   MAX_PRINTS  = 40;

    typedef struct {
        logic       mode;
        logic [7:0] slot;
        logic [3:0] row;
        logic [7:0] data;
        int         gap;
    } t_beat;

    typedef struct packed {
        logic       up;
        logic       lo;
        logic       sh;
        logic       la;
        logic       oe;
        logic [3:0] row;
        logic       done;
    } t_pins;

    logic                  i_clk;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_wr_en  = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_stall;
    logic                  i_mode       = MODE_TICK;
    logic [7:0]            i_write_slot = '0;
    logic [3:0]            i_write_row  = '0;
    logic [7:0]            i_write_byte = '0;
    logic                  o_out_valid;
    logic                  i_out_stall  = 1'b0;
    logic                  o_red_upper;
    logic                  o_red_lower;
    logic                  o_shift_pulse;
    logic                  o_latch_strobe;
    logic                  o_oe_level;
    logic [3:0]            o_row_select;
    logic                  o_frame_done;

    led_matrix_row_scan_driver_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_mode         (i_mode),
        .i_write_slot   (i_write_slot),
        .i_write_row    (i_write_row),
        .i_write_byte   (i_write_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_red_upper    (o_red_upper),
        .o_red_lower    (o_red_lower),
        .o_shift_pulse  (o_shift_pulse),
        .o_latch_strobe (o_latch_strobe),
        .o_oe_level     (o_oe_level),
        .o_row_select   (o_row_select),
        .o_frame_done   (o_frame_done)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // scan model state and register copies
    logic [7:0]            panel_mem [STORE_DEPTH] = '{default: '0};
    logic [3:0]            cur_row    = '0;
    logic [6:0]            cur_pair   = '0;
    logic [2:0]            cur_bit    = '0;
    t_phase                cur_phase  = PH_SHIFT;
    logic [15:0]           lit_count  = '0;
    logic [3:0]            addr_lines = '0;
    logic                  pass_true  = 1'b1;
    logic                  oe_on      = 1'b0;
    logic [QUARTER_W-1:0]  quarter    = 7'd16;
    logic [ON_TICKS_W-1:0] lit_len    = 16'd70;
    logic                  halted     = 1'b0;

    t_beat pending[$];
    t_pins pins_due[$];
    int    errors      = 0;
    int    pin_beats   = 0;
    int    cycle_count = 0;
    int    gap_count   = 0;
    int    rx_wait     = 0;
    int    hold_count  = 0;
    logic  hold_go     = 1'b0;
    logic  in_beat     = 1'b0;
    logic  out_beat    = 1'b0;
    bit    tx_calm     = 1'b0;
    bit    rx_calm     = 1'b0;

    function automatic int idle_draw(bit calm);
        if (calm || $urandom_range(0, 2) != 0) begin
            return 0;
        end
        return $urandom_range(0, MAX_IDLE);
    endfunction

    function automatic logic [7:0] pixel_byte(int slot, logic [3:0] r);
        logic [7:0] b;
        if (slot >= CHAR_SLOTS) begin
            return 8'h00;
        end
        b = panel_mem[slot * SCAN_ROWS + int'(r)];
        return pass_true ? b : ~b;
    endfunction

    task automatic next_pins(output t_pins p);
        int         q;
        int         s_up;
        int         s_lo;
        logic [7:0] b_up;
        logic [7:0] b_lo;
        p    = '0;
        p.oe = ~oe_on;
        q    = int'((quarter > QUARTER_MAX) ? QUARTER_MAX : quarter);
        if (halted) begin
            cur_row   = '0;
            cur_pair  = '0;
            cur_bit   = '0;
            cur_phase = PH_SHIFT;
            lit_count = '0;
        end else begin
            if (cur_phase == PH_SHIFT && int'(cur_pair) >= 2 * q) begin
                cur_pair  = '0;
                cur_bit   = '0;
                cur_phase = PH_LATCH;
            end
            if (cur_phase == PH_SHIFT) begin
                if (int'(cur_pair) < q) begin
                    s_up = int'(cur_pair);
                    s_lo = int'(cur_pair) + q;
                end else begin
                    s_up = int'(cur_pair) + q;
                    s_lo = int'(cur_pair) + 2 * q;
                end
                b_up = pixel_byte(s_up, cur_row);
                b_lo = pixel_byte(s_lo, cur_row);
                p.up = b_up[cur_bit];
                p.lo = b_lo[cur_bit];
                p.sh = 1'b1;
                if (cur_bit == 3'd7) begin
                    cur_bit = '0;
                    if (int'(cur_pair) + 1 >= 2 * q) begin
                        cur_pair  = '0;
                        cur_phase = PH_LATCH;
                    end else begin
                        cur_pair = cur_pair + 7'd1;
                    end
                end else begin
                    cur_bit = cur_bit + 3'd1;
                end
            end else if (cur_phase == PH_LATCH) begin
                p.la       = 1'b1;
                addr_lines = cur_row;
                lit_count  = '0;
                cur_phase  = PH_LIT;
            end else begin
                p.oe = oe_on;
                if (int'(lit_count) + 1 >= int'(lit_len)) begin
                    p.done    = (cur_row == 4'(SCAN_ROWS - 1));
                    cur_row   = cur_row + 4'd1;
                    lit_count = '0;
                    cur_pair  = '0;
                    cur_bit   = '0;
                    cur_phase = PH_SHIFT;
                end else begin
                    lit_count = lit_count + 16'd1;
                end
            end
        end
        p.row = addr_lines;
    endtask

    task automatic report(string what, int got, int want);
        errors++;
        if (errors <= MAX_PRINTS) begin
            $display("mismatch on %s at pin beat %0d: got %0d, want %0d",
                     what, pin_beats, got, want);
        end
    endtask

    task automatic compare_pins(t_pins got, t_pins want);
        if (got.up !== want.up)     report("red_upper", int'(got.up), int'(want.up));
        if (got.lo !== want.lo)     report("red_lower", int'(got.lo), int'(want.lo));
        if (got.sh !== want.sh)     report("shift_pulse", int'(got.sh), int'(want.sh));
        if (got.la !== want.la)     report("latch_strobe", int'(got.la), int'(want.la));
        if (got.oe !== want.oe)     report("oe_level", int'(got.oe), int'(want.oe));
        if (got.row !== want.row)   report("row_select", int'(got.row), int'(want.row));
        if (got.done !== want.done) report("frame_done", int'(got.done), int'(want.done));
    endtask

    always @(posedge i_clk) begin : watch
        t_pins want;
        t_pins got;
        logic  acc_in;
        logic  acc_out;
        acc_in  = i_rst_n && i_in_valid && o_in_stall === 1'b0;
        acc_out = i_rst_n && o_out_valid === 1'b1 && !i_out_stall;
        if (acc_in) begin
            if (i_mode == MODE_WRITE) begin
                panel_mem[int'(i_write_slot) * SCAN_ROWS + int'(i_write_row)] = i_write_byte;
            end else begin
                next_pins(want);
                pins_due.push_back(want);
            end
        end
        if (acc_out) begin
            got.up   = o_red_upper;
            got.lo   = o_red_lower;
            got.sh   = o_shift_pulse;
            got.la   = o_latch_strobe;
            got.oe   = o_oe_level;
            got.row  = o_row_select;
            got.done = o_frame_done;
            if (pins_due.size() == 0) begin
                report("unexpected pin beat", 1, 0);
            end else begin
                compare_pins(got, pins_due.pop_front());
            end
            pin_beats++;
        end
        in_beat  <= acc_in;
        out_beat <= acc_out;
    end

    always @(negedge i_clk) begin : drive
        t_beat nxt;
        logic  nv;
        nv = i_in_valid && !in_beat;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (!nv && pending.size() != 0) begin
            if (gap_count < pending[0].gap) begin
                gap_count++;
            end else begin
                nxt          = pending.pop_front();
                gap_count    = 0;
                nv           = 1'b1;
                i_mode       <= nxt.mode;
                i_write_slot <= nxt.slot;
                i_write_row  <= nxt.row;
                i_write_byte <= nxt.data;
            end
        end
        i_in_valid <= nv;
    end

    always @(negedge i_clk) begin
        if (out_beat) begin
            rx_wait = idle_draw(rx_calm);
        end else if (rx_wait != 0) begin
            rx_wait--;
        end
        i_out_stall <= (hold_count != 0) || (rx_wait != 0);
    end

    always @(posedge i_clk) begin
        if (hold_go) begin
            hold_count <= HOLD_CYCLES;
        end else if (hold_count != 0) begin
            hold_count <= hold_count - 1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_beat(logic mode, logic [7:0] slot, logic [3:0] row,
                             logic [7:0] data);
        t_beat b;
        b.mode = mode;
        b.slot = slot;
        b.row  = row;
        b.data = data;
        b.gap  = idle_draw(tx_calm);
        pending.push_back(b);
    endtask

    task automatic push_ticks(int n);
        repeat (n) push_beat(MODE_TICK, 8'($urandom), 4'($urandom), 8'($urandom));
    endtask

    task automatic settle();
        @(posedge i_clk);
        while (pending.size() != 0 || i_in_valid || pins_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (idx)
            CFG_DATA_POLARITY:     pass_true = val[0];
            CFG_OE_ACTIVE_LEVEL:   oe_on     = val[0];
            CFG_BYTES_PER_QUARTER: quarter   = val[QUARTER_W-1:0];
            CFG_ON_TICKS:          lit_len   = val[ON_TICKS_W-1:0];
            CFG_SCAN_STOP:         halted    = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic pol, logic oe, int q, int on, logic stop);
        write_reg(CFG_DATA_POLARITY, CFG_DATA_W'(pol));
        write_reg(CFG_OE_ACTIVE_LEVEL, CFG_DATA_W'(oe));
        write_reg(CFG_BYTES_PER_QUARTER, CFG_DATA_W'(q));
        write_reg(CFG_ON_TICKS, CFG_DATA_W'(on));
        write_reg(CFG_SCAN_STOP, CFG_DATA_W'(stop));
    endtask

    initial begin : stimulus
        int   sent;
        int   n;
        int   q;
        int   on;
        int   round;
        logic [7:0] slot;
        sent  = 0;
        round = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_beat(MODE_WRITE, 8'd0, 4'd0, 8'h01);
        push_beat(MODE_WRITE, 8'd16, 4'd0, 8'h80);
        push_beat(MODE_WRITE, 8'd1, 4'd0, 8'hA5);
        push_beat(MODE_WRITE, 8'd255, 4'd15, 8'hFF);
        push_ticks(9);
        settle();

        set_config(1'b0, 1'b1, 0, 0, 1'b0);
        push_ticks(4);
        settle();

        set_config(1'b1, 1'b0, 100, 65535, 1'b0);
        push_ticks(3);
        settle();
        write_reg(CFG_BYTES_PER_QUARTER, CFG_DATA_W'(0));
        push_ticks(4);
        settle();
        write_reg(CFG_ON_TICKS, CFG_DATA_W'(2));
        push_ticks(1);
        settle();

        write_reg(CFG_SCAN_STOP, CFG_DATA_W'(1));
        write_reg(CFG_IDX_W'($urandom_range(CFG_SCAN_STOP + 1, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom));
        push_ticks(2);
        settle();
        write_reg(CFG_SCAN_STOP, CFG_DATA_W'(0));
        push_ticks(1);
        settle();

        while (sent < RANDOM_BEATS) begin
            round++;
            case ($urandom_range(0, 7))
                0: q = 0;
                1: q = 1;
                2: q = int'(QUARTER_MAX);
                3: q = (1 << QUARTER_W) - 1;
                default: q = $urandom_range(1, 4);
            endcase
            case ($urandom_range(0, 5))
                0: on = 0;
                1: on = (1 << ON_TICKS_W) - 1;
                2: on = 1;
                default: on = $urandom_range(1, 6);
            endcase
            set_config(1'($urandom), 1'($urandom), q, on, $urandom_range(0, 7) == 0);
            tx_calm = $urandom_range(0, 3) == 0;
            rx_calm = $urandom_range(0, 3) == 0;
            if (round == 2) begin
                tx_calm = 1'b1;
                hold_go <= 1'b1;
                @(negedge i_clk);
                hold_go <= 1'b0;
                push_ticks(40);
                sent += 40;
            end
            if (q > int'(QUARTER_MAX)) begin
                q = int'(QUARTER_MAX);
            end
            n = $urandom_range(30, 70);
            repeat (n) begin
                if ($urandom_range(0, 3) == 0) begin
                    slot = (q != 0 && $urandom_range(0, 3) != 0) ?
                           8'($urandom_range(0, 4 * q - 1)) : 8'($urandom);
                    push_beat(MODE_WRITE, slot, 4'($urandom), 8'($urandom));
                end else begin
                    push_ticks(1);
                end
            end
            sent += n;
            settle();
        end

        repeat (8) @(negedge i_clk);
        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ led_matrix_row_scan_driver_core.f @@
hdl/lmsd_pkg.sv
hdl/lmsd_store.sv
hdl/lmsd_scan.sv
hdl/led_matrix_row_scan_driver_core.sv
bench/tb.sv
